/* rtl/core/vhd_pkg.sv */
// ---------------------------------------------------------------------------
// vhd_pkg: shared types and constants for the vector heading core
// Holds the fixed-point formats, the quadrant modes, the per-item tag that
// travels beside the CORDIC data, and the arctangent table in degrees.
// ---------------------------------------------------------------------------
package vhd_pkg;

   localparam int COORD_BITS  = 24;
   localparam int ITERATIONS  = 16;

   // Coordinate differences are exact at one bit more than a coordinate.
   localparam int DIFF_W      = COORD_BITS + 1;
   // Magnitudes are scaled up so that the micro-rotations keep fraction bits.
   localparam int GUARD       = 58 - COORD_BITS;
   // Scaled magnitude plus CORDIC gain headroom plus sign.
   localparam int XY_W        = COORD_BITS + GUARD + 3;
   // Angle accumulator: degrees * 2^23, signed.
   localparam int Z_W         = 32;
   localparam int ROUND_SHIFT = 16;
   localparam int HEAD_W      = 16;
   // First-quadrant angle in 1/128 degree: 0..11520.
   localparam int T_W         = 14;
   localparam int TABLE_LEN   = 24;

   localparam logic [HEAD_W-1:0] QUARTER       = 16'd11520;
   localparam logic [HEAD_W-1:0] HALF          = 16'd23040;
   localparam logic [HEAD_W-1:0] THREE_QUARTER = 16'd34560;
   localparam logic [HEAD_W-1:0] FULL          = 16'd46080;
   localparam logic [HEAD_W-1:0] EAST          = 16'd0;

   localparam logic signed [Z_W-1:0] Z_MAX   = Z_W'(QUARTER) << ROUND_SHIFT;
   localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1) << (ROUND_SHIFT - 1);

   // How the final heading is formed from the first-quadrant angle t.
   typedef enum logic [2:0] {
      MODE_FIXED,   // heading taken from the tag (coincident or on an axis)
      MODE_NE,      // t
      MODE_NW,      // half turn - t
      MODE_SW,      // half turn + t
      MODE_SE       // full turn - t, wrapping to zero
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic              same_point;
      logic [HEAD_W-1:0] fixed_heading;
   } tag_type;

   // atan(2^-idx) in degrees * 2^23, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] value;
      case (idx)
         0:       value = 32'sd377487360;
         1:       value = 32'sd222843801;
         2:       value = 32'sd117744544;
         3:       value = 32'sd59768969;
         4:       value = 32'sd30000467;
         5:       value = 32'sd15014858;
         6:       value = 32'sd7509261;
         7:       value = 32'sd3754860;
         8:       value = 32'sd1877459;
         9:       value = 32'sd938733;
         10:      value = 32'sd469367;
         11:      value = 32'sd234683;
         12:      value = 32'sd117342;
         13:      value = 32'sd58671;
         14:      value = 32'sd29335;
         15:      value = 32'sd14668;
         16:      value = 32'sd7334;
         17:      value = 32'sd3667;
         18:      value = 32'sd1833;
         19:      value = 32'sd917;
         20:      value = 32'sd458;
         21:      value = 32'sd229;
         22:      value = 32'sd115;
         23:      value = 32'sd57;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

/* rtl/core/vhd_prep.sv */
// ---------------------------------------------------------------------------
// vhd_prep: difference and classification stages
// Stage A forms the exact coordinate differences. Stage B takes magnitudes,
// scales them for the CORDIC and picks the quadrant mode or fixed heading.
// ---------------------------------------------------------------------------
module vhd_prep import vhd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [COORD_BITS-1:0]   from_x,
   input  logic [COORD_BITS-1:0]   from_y,
   input  logic [COORD_BITS-1:0]   to_x,
   input  logic [COORD_BITS-1:0]   to_y,
   input  logic [HEAD_W-1:0]       fallback_heading,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [XY_W-1:0]  out_x,
   output logic signed [XY_W-1:0]  out_y,
   output tag_type                 out_tag
);

   logic                   a_vld_ff;
   logic [DIFF_W-1:0]      dx_ff;
   logic [DIFF_W-1:0]      dy_ff;
   logic [HEAD_W-1:0]      fb_ff;
   logic [DIFF_W-1:0]      dx_in;
   logic [DIFF_W-1:0]      dy_in;
   logic                   a_ready;

   logic                   b_vld_ff;
   logic signed [XY_W-1:0] x_ff;
   logic signed [XY_W-1:0] y_ff;
   tag_type                tag_ff;
   logic signed [XY_W-1:0] x_in;
   logic signed [XY_W-1:0] y_in;
   tag_type                tag_in;
   logic                   b_ready;

   logic                   dx_neg;
   logic                   dy_neg;
   logic                   dx_zero;
   logic                   dy_zero;
   logic [DIFF_W-1:0]      mag_x;
   logic [DIFF_W-1:0]      mag_y;

   assign b_ready  = ~b_vld_ff | out_ready;
   assign a_ready  = ~a_vld_ff | b_ready;
   assign in_ready = a_ready;

   // sign-extend by one bit so the difference never wraps
   assign dx_in = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
   assign dy_in = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_ready) begin
         a_vld_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         fb_ff <= fallback_heading;
      end
   end

   assign dx_neg  = dx_ff[DIFF_W-1];
   assign dy_neg  = dy_ff[DIFF_W-1];
   assign dx_zero = (dx_ff == '0);
   assign dy_zero = (dy_ff == '0);
   assign mag_x   = dx_neg ? (~dx_ff + DIFF_W'(1)) : dx_ff;
   assign mag_y   = dy_neg ? (~dy_ff + DIFF_W'(1)) : dy_ff;
   assign x_in    = XY_W'(mag_x) << GUARD;
   assign y_in    = XY_W'(mag_y) << GUARD;

   always_comb begin
      tag_in.mode          = MODE_FIXED;
      tag_in.same_point    = 1'b0;
      tag_in.fixed_heading = EAST;
      if (dx_zero && dy_zero) begin
         tag_in.same_point    = 1'b1;
         tag_in.fixed_heading = fb_ff;
      end else if (dy_zero) begin
         tag_in.fixed_heading = dx_neg ? HALF : EAST;
      end else if (dx_zero) begin
         tag_in.fixed_heading = dy_neg ? QUARTER : THREE_QUARTER;
      end else if (!dx_neg && dy_neg) begin
         tag_in.mode = MODE_NE;
      end else if (dx_neg && dy_neg) begin
         tag_in.mode = MODE_NW;
      end else if (dx_neg) begin
         tag_in.mode = MODE_SW;
      end else begin
         tag_in.mode = MODE_SE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_ready) begin
         b_vld_ff <= a_vld_ff;
      end
      if (b_ready && a_vld_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_tag   = tag_ff;

endmodule

/* rtl/core/vhd_cordic.sv */
// ---------------------------------------------------------------------------
// vhd_cordic: vectoring CORDIC pipeline
// One register stage per micro-rotation; each stage drives y toward zero and
// accumulates the rotated angle in degrees * 2^23.
// ---------------------------------------------------------------------------
module vhd_cordic import vhd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [XY_W-1:0]  in_x,
   input  logic signed [XY_W-1:0]  in_y,
   input  tag_type                 in_tag,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [Z_W-1:0]   out_z,
   output tag_type                 out_tag
);

   logic                   vld_ff      [ITERATIONS];
   logic signed [XY_W-1:0] x_ff        [ITERATIONS];
   logic signed [XY_W-1:0] y_ff        [ITERATIONS];
   logic signed [Z_W-1:0]  z_ff        [ITERATIONS];
   tag_type                tag_ff      [ITERATIONS];
   logic                   stage_ready [ITERATIONS];

   logic                   src_valid   [ITERATIONS];
   logic signed [XY_W-1:0] src_x       [ITERATIONS];
   logic signed [XY_W-1:0] src_y       [ITERATIONS];
   logic signed [Z_W-1:0]  src_z       [ITERATIONS];
   tag_type                src_tag     [ITERATIONS];

   for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;
      logic                   y_neg;

      if (g == 0) begin : g_first
         assign src_valid[g] = in_valid;
         assign src_x[g]     = in_x;
         assign src_y[g]     = in_y;
         assign src_z[g]     = '0;
         assign src_tag[g]   = in_tag;
      end else begin : g_next
         assign src_valid[g] = vld_ff[g-1];
         assign src_x[g]     = x_ff[g-1];
         assign src_y[g]     = y_ff[g-1];
         assign src_z[g]     = z_ff[g-1];
         assign src_tag[g]   = tag_ff[g-1];
      end

      if (g == ITERATIONS - 1) begin : g_last_rdy
         assign stage_ready[g] = ~vld_ff[g] | out_ready;
      end else begin : g_mid_rdy
         assign stage_ready[g] = ~vld_ff[g] | stage_ready[g+1];
      end

      // arithmetic shifts floor toward minus infinity
      assign xs    = src_x[g] >>> g;
      assign ys    = src_y[g] >>> g;
      assign y_neg = src_y[g][XY_W-1];

      always_comb begin
         if (y_neg) begin
            x_in = src_x[g] - ys;
            y_in = src_y[g] + xs;
            z_in = src_z[g] - atan_entry(g);
         end else begin
            x_in = src_x[g] + ys;
            y_in = src_y[g] - xs;
            z_in = src_z[g] + atan_entry(g);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            vld_ff[g] <= src_valid[g];
         end
         if (stage_ready[g] && src_valid[g]) begin
            x_ff[g]   <= x_in;
            y_ff[g]   <= y_in;
            z_ff[g]   <= z_in;
            tag_ff[g] <= src_tag[g];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = vld_ff[ITERATIONS-1];
   assign out_z     = z_ff[ITERATIONS-1];
   assign out_tag   = tag_ff[ITERATIONS-1];

endmodule

/* rtl/core/vhd_finish.sv */
// ---------------------------------------------------------------------------
// vhd_finish: rounding and quadrant stages
// Stage C clamps the angle and rounds it to 1/128 degree. Stage D places it
// in its quadrant and holds the result item for the output side.
// ---------------------------------------------------------------------------
module vhd_finish import vhd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [Z_W-1:0]   in_z,
   input  tag_type                 in_tag,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [HEAD_W-1:0]       out_heading,
   output logic                    out_same_point
);

   logic                   c_vld_ff;
   logic [T_W-1:0]         t_ff;
   tag_type                tag_ff;
   logic [T_W-1:0]         t_in;
   logic signed [Z_W-1:0]  z_clamp;
   logic signed [Z_W-1:0]  z_round;
   logic                   c_ready;

   logic                   d_vld_ff;
   logic [HEAD_W-1:0]      heading_ff;
   logic                   same_ff;
   logic [HEAD_W-1:0]      heading_in;
   logic [HEAD_W-1:0]      t_wide;
   logic                   d_ready;

   assign d_ready  = ~d_vld_ff | out_ready;
   assign c_ready  = ~c_vld_ff | d_ready;
   assign in_ready = c_ready;

   always_comb begin
      if (in_z < 0) begin
         z_clamp = '0;
      end else if (in_z > Z_MAX) begin
         z_clamp = Z_MAX;
      end else begin
         z_clamp = in_z;
      end
   end

   // round half up to 1/128 degree
   assign z_round = z_clamp + Z_ROUND;
   assign t_in    = z_round[ROUND_SHIFT +: T_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (c_ready) begin
         c_vld_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         t_ff   <= t_in;
         tag_ff <= in_tag;
      end
   end

   assign t_wide = HEAD_W'(t_ff);

   always_comb begin
      case (tag_ff.mode)
         MODE_FIXED: heading_in = tag_ff.fixed_heading;
         MODE_NE:    heading_in = t_wide;
         MODE_NW:    heading_in = HALF - t_wide;
         MODE_SW:    heading_in = HALF + t_wide;
         MODE_SE:    heading_in = (t_wide == '0) ? EAST : (FULL - t_wide);
         default:    heading_in = tag_ff.fixed_heading;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (d_ready) begin
         d_vld_ff <= c_vld_ff;
      end
      if (d_ready && c_vld_ff) begin
         heading_ff <= heading_in;
         same_ff    <= tag_ff.same_point;
      end
   end

   assign out_valid      = d_vld_ff;
   assign out_heading    = heading_ff;
   assign out_same_point = same_ff;

endmodule

/* rtl/core/vector_heading_degrees_core.sv */
// ---------------------------------------------------------------------------
// vector_heading_degrees_core: heading from a current to a target grid point
// Pipeline: 20 register stages (2 prep stages, one stage per CORDIC
//   micro-rotation, 2 finish stages).
// Throughput: one item per cycle unless the output stalls; every stage
//   has its own valid bit and advances when empty or its successor moves.
// Reset: synchronous, active high; clears all valid bits, drops items in flight.
// ---------------------------------------------------------------------------
module vector_heading_degrees_core import vhd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request item
   input  logic         req_tvalid,
   output logic         req_tready,
   // [23:0] from_x, [47:24] from_y, [71:48] to_x, [95:72] to_y,
   // [111:96] fallback_heading
   input  logic [111:0] req_tdata,
   // response item
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] heading
   output logic [15:0]  rsp_tdata,
   // [0] same_point
   output logic         rsp_tuser
);

   // Unpack the request fields.
   logic [COORD_BITS-1:0]  from_x;
   logic [COORD_BITS-1:0]  from_y;
   logic [COORD_BITS-1:0]  to_x;
   logic [COORD_BITS-1:0]  to_y;
   logic [HEAD_W-1:0]      fallback_heading;

   // Prep -> CORDIC.
   logic                   prep_valid;
   logic                   prep_ready;
   logic signed [XY_W-1:0] prep_x;
   logic signed [XY_W-1:0] prep_y;
   tag_type                prep_tag;

   // CORDIC -> finish.
   logic                   cordic_valid;
   logic                   cordic_ready;
   logic signed [Z_W-1:0]  cordic_z;
   tag_type                cordic_tag;

   assign from_x           = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign from_y           = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign to_x             = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign to_y             = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign fallback_heading = req_tdata[4*COORD_BITS +: HEAD_W];

   // Form differences, classify direction, scale magnitudes.
   vhd_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .from_x           (from_x),
      .from_y           (from_y),
      .to_x             (to_x),
      .to_y             (to_y),
      .fallback_heading (fallback_heading),
      .out_valid        (prep_valid),
      .out_ready        (prep_ready),
      .out_x            (prep_x),
      .out_y            (prep_y),
      .out_tag          (prep_tag)
   );

   // Resolve atan(|dy|/|dx|) one micro-rotation per stage.
   vhd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_x      (prep_x),
      .in_y      (prep_y),
      .in_tag    (prep_tag),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_z     (cordic_z),
      .out_tag   (cordic_tag)
   );

   // Round, place in quadrant, hold the result item.
   vhd_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (cordic_valid),
      .in_ready       (cordic_ready),
      .in_z           (cordic_z),
      .in_tag         (cordic_tag),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_heading    (rsp_tdata),
      .out_same_point (rsp_tuser)
   );

   // A computed heading always lies inside one full turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata < FULL)
      else $error("heading outside one full turn");

   // Input back-pressure only when every stage is full and the output stalls.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
